FILE: sv/nco_pkg.sv
// ----------------------------------------------------------------------------
// nco_pkg
// Shared types, register codes and the quarter-wave sine generator used to
// build the oscillator's lookup table at elaboration.
// ----------------------------------------------------------------------------
package nco_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_INC   = 2'd0,
    CFG_AMPLITUDE   = 2'd1,
    CFG_START_PHASE = 2'd2
  } cfg_reg_e;

  // Amplitude is unsigned Q0.16, table entries are unsigned Q1.30
  localparam int unsigned AMP_BITS        = 16;
  localparam int unsigned ENTRY_FRAC_BITS = 30;
  localparam int unsigned ENTRY_BITS      = 31;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Per-stage load enables of the sample pipeline
  typedef struct packed {
    logic phase_ld;  // phase top bits register
    logic rom_ld;    // table read data register
    logic mul_ld;    // product register
    logic out_ld;    // output sample register
  } pipe_en_t;

  // Entry k of a quarter-wave table with 2^addr_bits entries:
  // sin(pi/2 * (k + 0.5) / 2^addr_bits) in Q30, from a truncated Taylor series.
  function automatic logic [ENTRY_BITS-1:0] quarter_sine(int unsigned k,
                                                         int unsigned addr_bits);
    logic [63:0]        num;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    num  = HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1);
    x    = (num + (64'd1 << addr_bits)) >> (addr_bits + 1);
    x2   = (x * x) >> ENTRY_FRAC_BITS;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> ENTRY_FRAC_BITS;
      unique case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if ((n % 2) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    return acc[ENTRY_BITS-1:0];
  endfunction

endpackage

FILE: sv/nco_phase.sv
// ----------------------------------------------------------------------------
// nco_phase
// Phase accumulator with its increment register; registers the top table
// address bits of the advanced phase for each sample.
// ----------------------------------------------------------------------------
module nco_phase import nco_pkg::*; #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                         step_i,
  input  pipe_en_t                     en_i,
  output logic [TABLE_ADDR_BITS+1:0]   top_o
);

  localparam int unsigned TOP_BITS = TABLE_ADDR_BITS + 2;

  logic [PHASE_BITS-1:0]      acc_q, acc_d;
  logic [PHASE_BITS-1:0]      inc_q, inc_d;
  logic [PHASE_BITS-1:0]      phase_next;
  logic [PHASE_BITS-1:0]      cfg_phase;
  logic [2*CFG_DATA_BITS-1:0] cfg_wide;
  logic [TOP_BITS-1:0]        top_d;
  logic [TOP_BITS-1:0]        top_q;

  // Fit written word to the accumulator width
  assign cfg_wide  = {{CFG_DATA_BITS{1'b0}}, cfg_data_i};
  assign cfg_phase = cfg_wide[PHASE_BITS-1:0];

  // Advance by one increment, wrapping modulo one turn
  assign phase_next = acc_q + inc_q;

  // Register writes; a start phase write reloads the accumulator
  always_comb begin
    inc_d = inc_q;
    acc_d = acc_q;
    if (cfg_valid_i && (cfg_index_i == CFG_PHASE_INC)) begin
      inc_d = cfg_phase;
    end
    if (cfg_valid_i && (cfg_index_i == CFG_START_PHASE)) begin
      acc_d = cfg_phase;
    end else if (step_i) begin
      acc_d = phase_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      inc_q <= '0;
    end else begin
      acc_q <= acc_d;
      inc_q <= inc_d;
    end
  end

  // Take the quadrant and table index from the top phase bits
  if (PHASE_BITS >= TOP_BITS) begin : g_top_slice
    assign top_d = phase_next[PHASE_BITS-1 -: TOP_BITS];
  end else begin : g_top_pad
    assign top_d = {phase_next, {(TOP_BITS-PHASE_BITS){1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.phase_ld) begin
      top_q <= top_d;
    end
  end

  assign top_o = top_q;

endmodule

FILE: sv/nco_rom.sv
// ----------------------------------------------------------------------------
// nco_rom
// Quarter-wave sine table with two registered read ports, one for the cosine
// and one for the sine of the same phase, plus the sign of each.
// ----------------------------------------------------------------------------
module nco_rom import nco_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                       clk_i,
  input  pipe_en_t                   en_i,
  input  logic [TABLE_ADDR_BITS+1:0] top_i,
  output logic [ENTRY_BITS-1:0]      cos_entry_o,
  output logic [ENTRY_BITS-1:0]      sin_entry_o,
  output logic                       cos_neg_o,
  output logic                       sin_neg_o
);

  localparam int unsigned TAB_N = 1 << TABLE_ADDR_BITS;

  typedef logic [ENTRY_BITS-1:0] rom_t [TAB_N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TAB_N; k++) begin
      r[k] = quarter_sine(k, TABLE_ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS-1:0] cos_addr;
  logic [TABLE_ADDR_BITS-1:0] sin_addr;
  logic [ENTRY_BITS-1:0]      cos_q, sin_q;
  logic                       cos_neg_q, sin_neg_q;

  assign quad = top_i[TABLE_ADDR_BITS+1 -: 2];
  assign idx  = top_i[TABLE_ADDR_BITS-1:0];

  // Odd quadrants read the table mirrored; cosine sits one quadrant ahead
  assign sin_addr = quad[0] ? ~idx : idx;
  assign cos_addr = quad[0] ? idx : ~idx;

  // Read both ports and hold the signs alongside
  always_ff @(posedge clk_i) begin
    if (en_i.rom_ld) begin
      cos_q     <= ROM[cos_addr];
      sin_q     <= ROM[sin_addr];
      cos_neg_q <= quad[1] ^ quad[0];
      sin_neg_q <= quad[1];
    end
  end

  assign cos_entry_o = cos_q;
  assign sin_entry_o = sin_q;
  assign cos_neg_o   = cos_neg_q;
  assign sin_neg_o   = sin_neg_q;

endmodule

FILE: sv/nco_scale.sv
// ----------------------------------------------------------------------------
// nco_scale
// Scales one table entry by the amplitude, rounds half up to the output
// width, saturates at full scale and applies the sign.
// ----------------------------------------------------------------------------
module nco_scale import nco_pkg::*; #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                       clk_i,
  input  pipe_en_t                   en_i,
  input  logic [AMP_BITS-1:0]        amplitude_i,
  input  logic [ENTRY_BITS-1:0]      entry_i,
  input  logic                       neg_i,
  output logic signed [OUT_BITS-1:0] sample_o
);

  localparam int unsigned PROD_BITS   = AMP_BITS + ENTRY_BITS;
  localparam int unsigned ROUND_SHIFT = AMP_BITS + ENTRY_FRAC_BITS + 1 - OUT_BITS;
  localparam int unsigned MAG_BITS    = PROD_BITS + 1 - ROUND_SHIFT;
  localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS+1)'(1) << (ROUND_SHIFT - 1);
  localparam logic [MAG_BITS-1:0] MAG_MAX = (MAG_BITS)'((1 << (OUT_BITS - 1)) - 1);

  logic [PROD_BITS-1:0]       prod_d, prod_q;
  logic                       neg_q;
  logic [PROD_BITS:0]         rounded;
  logic [MAG_BITS-1:0]        mag;
  logic [OUT_BITS-1:0]        mag_sat;
  logic signed [OUT_BITS-1:0] sample_d, sample_q;

  // Multiply amplitude by the table entry
  assign prod_d = amplitude_i * entry_i;

  always_ff @(posedge clk_i) begin
    if (en_i.mul_ld) begin
      prod_q <= prod_d;
      neg_q  <= neg_i;
    end
  end

  // Round half up, clamp to full scale, then negate if needed
  assign rounded  = {1'b0, prod_q} + ROUND_HALF;
  assign mag      = rounded[PROD_BITS:ROUND_SHIFT];
  assign mag_sat  = (mag > MAG_MAX) ? MAG_MAX[OUT_BITS-1:0] : mag[OUT_BITS-1:0];
  assign sample_d = neg_q ? $signed(-mag_sat) : $signed(mag_sat);

  always_ff @(posedge clk_i) begin
    if (en_i.out_ld) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

FILE: sv/nco_quadrature_oscillator.sv
// ----------------------------------------------------------------------------
// nco_quadrature_oscillator
// Quadrature numerically controlled oscillator with quarter-wave table.
// ----------------------------------------------------------------------------
// Each accepted word with sample_request set advances the phase accumulator
// by phase_increment and yields one in_phase/quadrature pair equal to
// amplitude times cos/sin of the new phase; a word with sample_request clear
// is taken and dropped. Writing start_phase reloads the accumulator. The
// block takes one word per clock while the sample channel is not stalled;
// phase add, dual-port table read, amplitude multiply, and rounding with
// saturation each own one register stage. The sine table is a constant
// ROM built at elaboration, so no fill pass follows reset.
// Configuration writes are always taken and must land while no sample is
// in flight.
module nco_quadrature_oscillator import nco_pkg::*; #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned OUT_BITS        = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       sample_request_i,
  // sample channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] in_phase_o,
  output logic signed [OUT_BITS-1:0] quadrature_o,
  // configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i
);

  pipe_en_t                   en;
  logic                       v1_q, v2_q, v3_q, v4_q;
  logic                       adv1, adv2, adv3, adv4;
  logic                       step;
  logic [AMP_BITS-1:0]        amp_q;
  logic [TABLE_ADDR_BITS+1:0] top;
  logic [ENTRY_BITS-1:0]      cos_entry, sin_entry;
  logic                       cos_neg, sin_neg;

  // Each stage moves when it is empty or the next one moves
  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign en.phase_ld = adv1;
  assign en.rom_ld   = adv2;
  assign en.mul_ld   = adv3;
  assign en.out_ld   = adv4;

  assign in_ready_o  = adv1;
  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_i && adv1 && sample_request_i;

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= step;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Hold the amplitude register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i == CFG_AMPLITUDE)) begin
      amp_q <= cfg_data_i[AMP_BITS-1:0];
    end
  end

  nco_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .en_i        (en),
    .top_o       (top)
  );

  nco_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i       (clk_i),
    .en_i        (en),
    .top_i       (top),
    .cos_entry_o (cos_entry),
    .sin_entry_o (sin_entry),
    .cos_neg_o   (cos_neg),
    .sin_neg_o   (sin_neg)
  );

  nco_scale #(
    .OUT_BITS (OUT_BITS)
  ) u_scale_i (
    .clk_i       (clk_i),
    .en_i        (en),
    .amplitude_i (amp_q),
    .entry_i     (cos_entry),
    .neg_i       (cos_neg),
    .sample_o    (in_phase_o)
  );

  nco_scale #(
    .OUT_BITS (OUT_BITS)
  ) u_scale_q (
    .clk_i       (clk_i),
    .en_i        (en),
    .amplitude_i (amp_q),
    .entry_i     (sin_entry),
    .neg_i       (sin_neg),
    .sample_o    (quadrature_o)
  );

  assign out_valid_o = v4_q;

endmodule

FILE: sv/nco_checker.sv
// ----------------------------------------------------------------------------
// nco_checker
// Port-level checks for the oscillator, bound to every instance.
// ----------------------------------------------------------------------------
module nco_checker #(
  parameter int unsigned OUT_BITS = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [OUT_BITS-1:0] in_phase_o,
  input logic signed [OUT_BITS-1:0] quadrature_o
);

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Stalled word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("sample dropped while stalled");

  // Stalled word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(in_phase_o) && $stable(quadrature_o))
    else $error("sample changed while stalled");

  // An empty or draining output stage lets a request in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("request stalled with free output stage");

  // Saturation keeps both outputs off the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_phase_o != MOST_NEG) && (quadrature_o != MOST_NEG))
    else $error("sample beyond full scale");

endmodule

bind nco_quadrature_oscillator nco_checker #(.OUT_BITS(OUT_BITS)) u_nco_checker (.*);

FILE: test/tb_nco_quadrature_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nco_quadrature_oscillator
// Self-checking bench for the quadrature oscillator. A directed plan and then
// random requests under several idle/stall mixes drive the request channel,
// with register writes between groups of requests. A local copy of the phase
// accumulator and of the quarter-wave table predicts every sample. Output
// words are compared in order against the predictions.
// ----------------------------------------------------------------------------
module tb_nco_quadrature_oscillator;
  import nco_pkg::*;

  localparam int PHASE_W     = 32;
  localparam int ADDR_W      = 10;
  localparam int OUT_W       = 16;
  localparam int QUARTER_LEN = 1 << ADDR_W;
  localparam int CLK_PERIOD  = 4;
  localparam int PIPE_DEPTH  = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNKS      = 12;
  localparam int CHUNK_LEN   = 30;

  // Index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  // pi/2 in Q30, used to place the table samples
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [47:0] FULL_SCALE = (48'd1 << (OUT_W - 1)) - 48'd1;

  typedef struct packed {
    logic signed [OUT_W-1:0] in_phase;
    logic signed [OUT_W-1:0] quadrature;
  } iq_sample_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0] value;  // register data, or request bit in bit 0
    logic                    typed;   // use the typed result below
    iq_sample_t              want;
  } plan_row_t;

  localparam iq_sample_t ZERO_IQ = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic sample_req = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic hold_off = 1'b0;

  logic in_ready;
  logic out_valid;
  logic cfg_ready;
  logic signed [OUT_W-1:0] in_phase;
  logic signed [OUT_W-1:0] quadrature;

  // Local copy of the oscillator state
  logic [ENTRY_BITS-1:0] sine_rom [QUARTER_LEN];
  logic [PHASE_W-1:0] lo_phase = '0;
  logic [PHASE_W-1:0] lo_step = '0;
  logic [AMP_BITS-1:0] lo_gain = '0;

  iq_sample_t samples_due [$];
  plan_row_t  plan [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int samples_checked = 0;
  int idle_requests = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  nco_quadrature_oscillator #(
    .PHASE_BITS     (PHASE_W),
    .TABLE_ADDR_BITS(ADDR_W),
    .OUT_BITS       (OUT_W)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_request_i(sample_req),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .in_phase_o      (in_phase),
    .quadrature_o    (quadrature),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sine in Q30 of an angle in Q30 radians, Taylor series up to x^17
  function automatic logic [ENTRY_BITS-1:0] taylor_sine(input logic [63:0] x);
    logic [63:0]        x_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x_sq = (x * x) >> ENTRY_FRAC_BITS;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x_sq) >> ENTRY_FRAC_BITS;
      term = term / (64'(2 * n) * 64'(2 * n + 1));
      if ((n & 1) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    return acc[ENTRY_BITS-1:0];
  endfunction

  // Scaled sine for one quadrant and table index, rounded and saturated
  function automatic logic signed [OUT_W-1:0] sine_level(input logic [1:0] quad,
                                                         input logic [ADDR_W-1:0] idx);
    logic [ENTRY_BITS-1:0] entry;
    logic [47:0]           prod;
    logic [47:0]           mag;
    // odd quadrants read the table mirrored
    entry = quad[0] ? sine_rom[~idx] : sine_rom[idx];
    prod  = 48'(lo_gain) * 48'(entry);
    mag   = (prod + (48'd1 << (46 - OUT_W))) >> (47 - OUT_W);
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    return quad[1] ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
  endfunction

  function automatic plan_row_t wr(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t rq(input logic req, input logic typed,
                                   input iq_sample_t want);
    plan_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.value[0] = req;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Drop the request valid and wait until the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Write one register while idle and mirror it locally
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PHASE_INC:   lo_step = value[PHASE_W-1:0];
      CFG_AMPLITUDE:   lo_gain = value[AMP_BITS-1:0];
      CFG_START_PHASE: lo_phase = value[PHASE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Offer one request word and log the sample it should produce
  task automatic put_request(input logic req, input logic typed, input iq_sample_t want);
    logic [ADDR_W+1:0] top;
    iq_sample_t        due;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample_req <= req;
    do @(posedge clk); while (!in_ready);
    if (req) begin
      // advance first, then look up the new phase
      lo_phase = lo_phase + lo_step;
      top = lo_phase[PHASE_W-1 -: ADDR_W + 2];
      due.in_phase   = sine_level(top[ADDR_W+1:ADDR_W] + 2'd1, top[ADDR_W-1:0]);
      due.quadrature = sine_level(top[ADDR_W+1:ADDR_W], top[ADDR_W-1:0]);
      samples_due.push_back(typed ? want : due);
    end else begin
      idle_requests++;
    end
  endtask

  // Pick a fresh register set for the next group of requests
  task automatic random_settings();
    logic [31:0] step;
    case ($urandom_range(3))
      0: step = $urandom;
      1: step = $urandom_range(32'h0040_0000);
      2: step = -$urandom_range(32'h0040_0000);
      default: step = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    write_reg(CFG_PHASE_INC, step);
    write_reg(CFG_AMPLITUDE, ($urandom_range(3) == 0) ? 32'h0000_FFFF : $urandom);
    if ($urandom_range(1)) begin
      write_reg(CFG_START_PHASE, $urandom);
    end
    if ($urandom_range(5) == 0) begin
      write_reg(CFG_SPARE, $urandom);
    end
  endtask

  // Accept and check output words; pick the ready pattern
  always @(posedge clk) begin
    iq_sample_t exp_iq;
    if (rst_n && out_valid && out_ready) begin
      if (samples_due.size() == 0) begin
        $display("%0t: unexpected sample in_phase %0d quadrature %0d",
                 $time, in_phase, quadrature);
        errors++;
      end else begin
        exp_iq = samples_due.pop_front();
        if (in_phase !== exp_iq.in_phase) begin
          $display("%0t: in_phase expected %0d got %0d", $time, exp_iq.in_phase, in_phase);
          errors++;
        end
        if (quadrature !== exp_iq.quadrature) begin
          $display("%0t: quadrature expected %0d got %0d",
                   $time, exp_iq.quadrature, quadrature);
          errors++;
        end
        samples_checked++;
      end
    end
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Bound the run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [63:0] angle;
    logic        req;
    int          sent;

    // fill the local quarter-wave table
    for (int k = 0; k < QUARTER_LEN; k++) begin
      angle = (QUARTER_TURN_Q30 * (64'(k) * 64'd2 + 64'd1) + (64'd1 << ADDR_W))
              >> (ADDR_W + 1);
      sine_rom[k] = taylor_sine(angle);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan: reset state, idle request, extremes of every register
    plan.push_back(rq(1'b1, 1'b1, ZERO_IQ));  // zero amplitude after reset
    plan.push_back(rq(1'b0, 1'b0, ZERO_IQ));  // idle request, no sample
    plan.push_back(wr(CFG_AMPLITUDE, 32'h0000_FFFF));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(wr(CFG_PHASE_INC, 32'h4000_0000));  // quarter turn per sample
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(wr(CFG_PHASE_INC, 32'hFFFF_FFFF));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(rq(1'b0, 1'b0, ZERO_IQ));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(wr(CFG_START_PHASE, 32'hFFFF_FFFF));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(wr(CFG_START_PHASE, 32'h0));
    plan.push_back(wr(CFG_PHASE_INC, 32'h0010_0000));  // one table step
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(wr(CFG_AMPLITUDE, 32'h0));
    plan.push_back(rq(1'b1, 1'b1, ZERO_IQ));
    plan.push_back(wr(CFG_SPARE, 32'hFFFF_FFFF));  // ignored, amplitude stays zero
    plan.push_back(rq(1'b1, 1'b1, ZERO_IQ));
    plan.push_back(wr(CFG_AMPLITUDE, 32'h1));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));
    plan.push_back(wr(CFG_AMPLITUDE, 32'hFFFF_8000));
    plan.push_back(rq(1'b1, 1'b0, ZERO_IQ));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        put_request(plan[i].value[0], plan[i].typed, plan[i].want);
      end
    end

    // random groups, cycling through the idle/stall mixes
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      random_settings();
      case (chunk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 79; end
        default: begin send_idle_pct = 11; recv_stall_pct <= 11; end
      endcase
      sent = 0;
      while (sent < CHUNK_LEN) begin
        req = ($urandom_range(9) != 0);
        put_request(req, 1'b0, ZERO_IQ);
        if (req) sent++;
      end
    end

    // hold the sample side off while requests keep coming
    random_settings();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (40) put_request(1'b1, 1'b0, ZERO_IQ);

    settle();
    if (samples_due.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, samples_due.size());
      errors++;
    end

    $display("checked %0d samples, %0d idle requests dropped, %0d register writes",
             samples_checked, idle_requests, reg_writes);
    $display("mixes: free run, sender gaps, receiver stalls, both, and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/nco_pkg.sv
sv/nco_phase.sv
sv/nco_rom.sv
sv/nco_scale.sv
sv/nco_quadrature_oscillator.sv
sv/nco_checker.sv
test/tb_nco_quadrature_oscillator.sv
